FILE: hw/rtl/assert_macros.svh
// Assertion macros shared by the RTL that checks itself.
// Expects signals named clk and rst_n in the including scope.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define BCSR_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define BCSR_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: hw/rtl/bcsr_pkg.sv
// Shared types, widths and codes for the BEV confidence splat raster.
// No dependencies; compiled first.
`timescale 1ns / 1ps
`default_nettype none

package bcsr_pkg;

  // field widths
  localparam int COORD_W    = 32;
  localparam int HALF_W     = 30;
  localparam int CELL_W     = 20;
  localparam int GRID_CNT_W = 10;
  localparam int NUM_W      = 31;  // (dx + half) and (half - dy) inside the window
  localparam int LABEL_W    = 3;
  localparam int CONF_IN_W  = 17;
  localparam int CONF_W     = 8;
  localparam int IO_ROW_W   = 9;
  localparam int STATUS_W   = 2;
  localparam int COLOR_W    = 8;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 32;

  localparam int GRID_MIN = 32;

  // register reset values
  localparam logic [HALF_W-1:0]     RST_HALF = HALF_W'(50000);
  localparam logic [CELL_W-1:0]     RST_CELL = CELL_W'(200);
  localparam logic [GRID_CNT_W-1:0] RST_GRID = GRID_CNT_W'(500);

  // confidence scaling
  localparam logic [CONF_IN_W-1:0] CONF_ONE   = 17'h10000;
  localparam logic [CONF_W-1:0]    CONF_SCALE = 8'd255;

  // register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_CENTER_X = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_CENTER_Y = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_HALF     = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_CELL     = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_GRID     = 3'd4;

  // labels
  localparam logic [LABEL_W-1:0] LBL_NONE       = 3'd0;
  localparam logic [LABEL_W-1:0] LBL_ROAD       = 3'd1;
  localparam logic [LABEL_W-1:0] LBL_SIDEWALK   = 3'd2;
  localparam logic [LABEL_W-1:0] LBL_BUILDING   = 3'd3;
  localparam logic [LABEL_W-1:0] LBL_VEGETATION = 3'd4;
  localparam logic [LABEL_W-1:0] LBL_DYNAMIC    = 3'd5;
  localparam logic [LABEL_W-1:0] LBL_OTHER      = 3'd6;
  localparam logic [LABEL_W-1:0] LBL_INVALID    = 3'd7;

  // result status
  localparam logic [STATUS_W-1:0] ST_WRITTEN = 2'd0;
  localparam logic [STATUS_W-1:0] ST_OUTSIDE = 2'd1;
  localparam logic [STATUS_W-1:0] ST_WEAKER  = 2'd2;
  localparam logic [STATUS_W-1:0] ST_READ    = 2'd3;

  // one stored pixel, bit layout {trav, conf, label}
  typedef struct packed {
    logic              trav;
    logic [CONF_W-1:0] conf;
    logic [LABEL_W-1:0] label;
  } pix_t;

  typedef struct packed {
    logic [COLOR_W-1:0] b;
    logic [COLOR_W-1:0] g;
    logic [COLOR_W-1:0] r;
  } color_t;

  // divider status toward the sequencer
  typedef struct packed {
    logic busy;
    logic done;
  } div_stat_t;

  function automatic color_t label_color(input logic [LABEL_W-1:0] lbl);
    color_t c;
    case (lbl)
      LBL_ROAD:       c = '{b: 8'd70,  g: 8'd70,  r: 8'd70};
      LBL_SIDEWALK:   c = '{b: 8'd80,  g: 8'd120, r: 8'd160};
      LBL_BUILDING:   c = '{b: 8'd40,  g: 8'd40,  r: 8'd220};
      LBL_VEGETATION: c = '{b: 8'd40,  g: 8'd170, r: 8'd20};
      LBL_DYNAMIC:    c = '{b: 8'd0,   g: 8'd180, r: 8'd255};
      LBL_OTHER:      c = '{b: 8'd220, g: 8'd120, r: 8'd120};
      default:        c = '{b: 8'd180, g: 8'd180, r: 8'd180};
    endcase
    return c;
  endfunction

endpackage

`default_nettype wire

FILE: hw/rtl/bcsr_in_if.sv
// Request channel: valid/ready plus splat and read fields.
// Depends on bcsr_pkg for field widths.
`timescale 1ns / 1ps
`default_nettype none

interface bcsr_in_if import bcsr_pkg::*; ();
  logic                        valid;
  logic                        ready;
  logic                        req_type;
  logic signed [COORD_W-1:0]   point_x_mm;
  logic signed [COORD_W-1:0]   point_y_mm;
  logic        [LABEL_W-1:0]   point_label;
  logic        [CONF_IN_W-1:0] point_confidence;
  logic        [IO_ROW_W-1:0]  read_row;
  logic        [IO_ROW_W-1:0]  read_col;

  modport source (
    output valid, req_type, point_x_mm, point_y_mm, point_label,
           point_confidence, read_row, read_col,
    input  ready
  );

  modport sink (
    input  valid, req_type, point_x_mm, point_y_mm, point_label,
           point_confidence, read_row, read_col,
    output ready
  );
endinterface

`default_nettype wire

FILE: hw/rtl/bcsr_out_if.sv
// Result channel: valid/ready plus status, pixel and colour fields.
// Depends on bcsr_pkg for field widths.
`timescale 1ns / 1ps
`default_nettype none

interface bcsr_out_if import bcsr_pkg::*; ();
  logic                  valid;
  logic                  ready;
  logic [STATUS_W-1:0]   status;
  logic [IO_ROW_W-1:0]   cell_row;
  logic [IO_ROW_W-1:0]   cell_col;
  logic [LABEL_W-1:0]    pixel_label;
  logic [CONF_W-1:0]     pixel_confidence;
  logic                  pixel_traversable;
  logic [COLOR_W-1:0]    color_blue;
  logic [COLOR_W-1:0]    color_green;
  logic [COLOR_W-1:0]    color_red;

  modport source (
    output valid, status, cell_row, cell_col, pixel_label, pixel_confidence,
           pixel_traversable, color_blue, color_green, color_red,
    input  ready
  );

  modport sink (
    input  valid, status, cell_row, cell_col, pixel_label, pixel_confidence,
           pixel_traversable, color_blue, color_green, color_red,
    output ready
  );
endinterface

`default_nettype wire

FILE: hw/rtl/bcsr_div.sv
// Radix-2 restoring divider, one quotient bit per cycle, QW bits of quotient.
// Caller guarantees quotient < 2**QW. Depends on bcsr_pkg.
`timescale 1ns / 1ps
`default_nettype none

module bcsr_div import bcsr_pkg::*; #(
  parameter int QW = 9
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              start,
  input  logic [NUM_W-1:0]  dividend,
  input  logic [CELL_W-1:0] divisor,
  output div_stat_t         stat,
  output logic [QW-1:0]     quot
);

  localparam int DSW  = CELL_W + QW;
  localparam int WW   = (DSW > NUM_W) ? DSW : NUM_W;
  localparam int CNTW = $clog2(QW + 1);

  logic [NUM_W-1:0] rem_r;
  logic [DSW-1:0]   dsr_r;   // divisor aligned to the current quotient bit
  logic [QW-1:0]    quot_r;
  logic [CNTW-1:0]  cnt_r;
  logic             busy_r;
  logic             done_r;

  logic             fits;
  logic [NUM_W-1:0] rem_sub;

  assign fits    = WW'(rem_r) >= WW'(dsr_r);
  assign rem_sub = rem_r - NUM_W'(dsr_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        rem_r  <= dividend;
        dsr_r  <= DSW'(divisor) << (QW - 1);
        quot_r <= '0;
        cnt_r  <= CNTW'(QW);
        busy_r <= 1'b1;
      end else if (busy_r) begin
        if (fits) begin
          rem_r <= rem_sub;
        end
        quot_r <= {quot_r[QW-2:0], fits};
        dsr_r  <= dsr_r >> 1;
        cnt_r  <= cnt_r - CNTW'(1);
        if (cnt_r == CNTW'(1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  assign stat = '{busy: busy_r, done: done_r};
  assign quot = quot_r;

endmodule

`default_nettype wire

FILE: hw/rtl/bev_confidence_splat_raster.sv
// BEV confidence splat raster, top level.
// In-grid splat: S_DIFF, S_WIN, S_COLLD, S_COLDIV, S_ROWLD, S_ROWDIV and S_RD, then S_RMW
//   loads the result; the two row/column divisions on the shared divider set most of this.
//   A splat outside the window goes to S_REJ from S_WIN, one outside the grid from S_COLLD.
// Read request: S_RDQ, then S_RDOUT answers; requests are taken only in S_IDLE.
// Reset (rst_n low, synchronous) restores registers, then a clearing pass writes zero to all
//   GRID_MAX*GRID_MAX pixels, one per cycle; requests wait, configuration writes go through.
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"

module bev_confidence_splat_raster import bcsr_pkg::*; #(
  parameter int GRID_MAX = 512
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_idx,
  input  logic [CFG_DATA_W-1:0] cfg_wdata,
  bcsr_in_if.sink               in_ch,
  bcsr_out_if.source            out_ch
);

  localparam int RW    = $clog2(GRID_MAX);        // row/col index bits
  localparam int NW    = $clog2(GRID_MAX + 1);    // grid size in use
  localparam int CW    = (NW > IO_ROW_W) ? NW : IO_ROW_W;
  localparam int DEPTH = GRID_MAX * GRID_MAX;
  localparam int AW    = $clog2(DEPTH);
  localparam int PW    = NW + CELL_W;             // grid size times cell size
  localparam int CMPW  = (PW > NUM_W) ? PW : NUM_W;
  localparam int DXW   = COORD_W + 1;

  typedef enum logic [3:0] {
    S_IDLE, S_DIFF, S_WIN, S_COLLD, S_COLDIV, S_ROWLD, S_ROWDIV,
    S_RD, S_RMW, S_REJ, S_RDQ, S_RDOUT
  } state_t;

  // ---------------------------------------------------------------------------
  // Configuration registers
  // ---------------------------------------------------------------------------
  logic signed [COORD_W-1:0] cx_r, cy_r;
  logic [HALF_W-1:0]         half_r;
  logic [CELL_W-1:0]         cell_r;
  logic [GRID_CNT_W-1:0]     gc_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cx_r   <= '0;
      cy_r   <= '0;
      half_r <= RST_HALF;
      cell_r <= RST_CELL;
      gc_r   <= RST_GRID;
    end else if (cfg_we) begin
      case (cfg_idx)
        CFG_CENTER_X: cx_r   <= cfg_wdata;
        CFG_CENTER_Y: cy_r   <= cfg_wdata;
        CFG_HALF:     half_r <= cfg_wdata[HALF_W-1:0];
        CFG_CELL:     cell_r <= cfg_wdata[CELL_W-1:0];
        CFG_GRID:     gc_r   <= cfg_wdata[GRID_CNT_W-1:0];
        default: ;
      endcase
    end
  end

  // grid in use clamped to [GRID_MIN, GRID_MAX]; zero cell size acts as 1 mm
  logic [NW-1:0]     n_eff;
  logic [CELL_W-1:0] cell_eff;

  assign n_eff = (int'(gc_r) > GRID_MAX) ? NW'(GRID_MAX) :
                 (int'(gc_r) < GRID_MIN) ? NW'(GRID_MIN) : NW'(gc_r);
  assign cell_eff = (cell_r == '0) ? CELL_W'(1) : cell_r;

  // ---------------------------------------------------------------------------
  // Sequencer state and datapath registers
  // ---------------------------------------------------------------------------
  state_t                    state_r;
  logic                      clr_r;        // clearing pass running
  logic [AW-1:0]             clr_addr_r;

  logic signed [COORD_W-1:0] px_r, py_r;
  logic [LABEL_W-1:0]        label_r;
  logic [CONF_IN_W-1:0]      conf_in_r;
  logic [CW-1:0]             row_r, col_r;
  logic signed [DXW-1:0]     dx_r, dy_r;
  logic [CONF_W-1:0]         conf8_r;
  logic [PW-1:0]             ncell_r;
  logic [NUM_W-1:0]          numx_r, numy_r;
  logic [AW-1:0]             addr_r;
  logic                      rd_ok_r;

  // result register
  logic                      out_valid_r;
  logic [STATUS_W-1:0]       o_status_r;
  logic [IO_ROW_W-1:0]       o_row_r, o_col_r;
  pix_t                      o_pix_r;
  color_t                    o_color_r;

  // pixel memory
  pix_t                      mem [DEPTH];
  pix_t                      mem_q_r;
  logic                      mem_we, mem_re;
  logic [AW-1:0]             mem_waddr, mem_raddr;
  pix_t                      mem_wdata;

  // shared divider
  logic                      div_start;
  logic [NUM_W-1:0]          div_num;
  div_stat_t                 div_st;
  logic [RW-1:0]             div_q;

  // ---------------------------------------------------------------------------
  // Combinational helpers
  // ---------------------------------------------------------------------------
  logic                      in_acc;
  logic                      slot_free;   // result register empty or draining now
  logic signed [DXW-1:0]     dx_c, dy_c, half_s, numx_c, numy_c;
  logic                      win_c;
  logic                      reject_c;
  logic [CONF_IN_W-1:0]      conf_cl;
  logic [CONF_IN_W+CONF_W-1:0] conf_prod;
  logic                      rd_ok_c;
  logic                      weaker_c;
  pix_t                      new_pix;
  logic [AW-1:0]             addr_c;

  logic                      out_load;
  logic [STATUS_W-1:0]       ld_status;
  pix_t                      ld_pix;

  assign in_ch.ready = (state_r == S_IDLE) && !clr_r;
  assign in_acc      = in_ch.valid && in_ch.ready;
  assign slot_free   = !out_valid_r || out_ch.ready;

  assign dx_c   = $signed({px_r[COORD_W-1], px_r}) - $signed({cx_r[COORD_W-1], cx_r});
  assign dy_c   = $signed({py_r[COORD_W-1], py_r}) - $signed({cy_r[COORD_W-1], cy_r});
  assign half_s = $signed(DXW'(half_r));
  // window: -half <= d < half on both axes
  assign win_c  = (dx_r >= -half_s) && (dx_r < half_s) &&
                  (dy_r >= -half_s) && (dy_r < half_s);
  assign numx_c = dx_r + half_s;
  assign numy_c = half_s - dy_r;

  // quotient >= n exactly when numerator >= n*cell; keeps the divide to RW steps
  assign reject_c = (CMPW'(numx_r) >= CMPW'(ncell_r)) ||
                    (CMPW'(numy_r) >= CMPW'(ncell_r));

  // bit 16 set means >= 1.0
  assign conf_cl   = conf_in_r[CONF_IN_W-1] ? CONF_ONE : conf_in_r;
  assign conf_prod = (CONF_IN_W+CONF_W)'(conf_cl) * (CONF_IN_W+CONF_W)'(CONF_SCALE);

  assign rd_ok_c = (row_r < CW'(n_eff)) && (col_r < CW'(n_eff));
  assign addr_c  = AW'(row_r[RW-1:0]) * AW'(GRID_MAX) + AW'(col_r[RW-1:0]);

  assign weaker_c = conf8_r < mem_q_r.conf;
  // traversable is sticky
  assign new_pix  = '{trav:  mem_q_r.trav || (label_r == LBL_ROAD) || (label_r == LBL_SIDEWALK),
                      conf:  conf8_r,
                      label: label_r};

  assign div_start = ((state_r == S_COLLD) && !reject_c) || (state_r == S_ROWLD);
  assign div_num   = (state_r == S_ROWLD) ? numy_r : numx_r;

  // result load
  always_comb begin
    out_load  = 1'b0;
    ld_status = ST_OUTSIDE;
    ld_pix    = '0;
    case (state_r)
      S_REJ: begin
        out_load  = slot_free;
      end
      S_RMW: begin
        out_load  = slot_free;
        ld_status = weaker_c ? ST_WEAKER : ST_WRITTEN;
        ld_pix    = weaker_c ? mem_q_r : new_pix;
      end
      S_RDOUT: begin
        out_load  = slot_free;
        ld_status = ST_READ;
        ld_pix    = rd_ok_r ? mem_q_r : pix_t'('0);
      end
      default: ;
    endcase
  end

  // memory port control
  always_comb begin
    mem_we    = 1'b0;
    mem_waddr = addr_r;
    mem_wdata = '0;
    mem_re    = 1'b0;
    mem_raddr = addr_c;
    if (clr_r) begin
      mem_we    = 1'b1;
      mem_waddr = clr_addr_r;
    end else begin
      case (state_r)
        S_RDQ:   mem_re = rd_ok_c;
        S_RD:    mem_re = 1'b1;
        S_RMW: begin
          mem_we    = slot_free && !weaker_c;
          mem_wdata = new_pix;
        end
        S_RDOUT: mem_we = slot_free && rd_ok_r;   // read then clear
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
    if (mem_re) begin
      mem_q_r <= mem[mem_raddr];
    end
  end

  // ---------------------------------------------------------------------------
  // Shared divider: column first, then row
  // ---------------------------------------------------------------------------
  bcsr_div #(
    .QW (RW)
  ) u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend (div_num),
    .divisor  (cell_eff),
    .stat     (div_st),
    .quot     (div_q)
  );

  // ---------------------------------------------------------------------------
  // Sequencer
  // ---------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      clr_r       <= 1'b1;
      clr_addr_r  <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (clr_r) begin
        clr_addr_r <= clr_addr_r + AW'(1);
        if (clr_addr_r == AW'(DEPTH - 1)) begin
          clr_r <= 1'b0;
        end
      end

      if (out_load) begin
        out_valid_r <= 1'b1;
        o_status_r  <= ld_status;
        o_row_r     <= (ld_status == ST_OUTSIDE) ? IO_ROW_W'(0) : row_r[IO_ROW_W-1:0];
        o_col_r     <= (ld_status == ST_OUTSIDE) ? IO_ROW_W'(0) : col_r[IO_ROW_W-1:0];
        o_pix_r     <= ld_pix;
        o_color_r   <= (ld_status == ST_OUTSIDE) ? color_t'('0) : label_color(ld_pix.label);
      end else if (out_ch.ready) begin
        out_valid_r <= 1'b0;
      end

      case (state_r)
        S_IDLE: begin
          if (in_acc) begin
            px_r      <= in_ch.point_x_mm;
            py_r      <= in_ch.point_y_mm;
            label_r   <= (in_ch.point_label == LBL_INVALID) ? LBL_NONE : in_ch.point_label;
            conf_in_r <= in_ch.point_confidence;
            row_r     <= CW'(in_ch.read_row);
            col_r     <= CW'(in_ch.read_col);
            state_r   <= in_ch.req_type ? S_RDQ : S_DIFF;
          end
        end
        S_DIFF: begin
          dx_r    <= dx_c;
          dy_r    <= dy_c;
          conf8_r <= conf_prod[CONF_IN_W+CONF_W-2:CONF_IN_W-1];
          ncell_r <= PW'(n_eff) * PW'(cell_eff);
          state_r <= S_WIN;
        end
        S_WIN: begin
          numx_r  <= numx_c[NUM_W-1:0];
          numy_r  <= numy_c[NUM_W-1:0];
          state_r <= win_c ? S_COLLD : S_REJ;
        end
        S_COLLD: begin
          state_r <= reject_c ? S_REJ : S_COLDIV;
        end
        S_COLDIV: begin
          if (div_st.done) begin
            col_r   <= CW'(div_q);
            state_r <= S_ROWLD;
          end
        end
        S_ROWLD: begin
          state_r <= S_ROWDIV;
        end
        S_ROWDIV: begin
          if (div_st.done) begin
            row_r   <= CW'(div_q);
            state_r <= S_RD;
          end
        end
        S_RD: begin
          addr_r  <= addr_c;
          state_r <= S_RMW;
        end
        S_RDQ: begin
          addr_r  <= addr_c;
          rd_ok_r <= rd_ok_c;
          state_r <= S_RDOUT;
        end
        S_RMW, S_REJ, S_RDOUT: begin
          if (slot_free) begin
            state_r <= S_IDLE;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  // ---------------------------------------------------------------------------
  // Result port
  // ---------------------------------------------------------------------------
  assign out_ch.valid             = out_valid_r;
  assign out_ch.status            = o_status_r;
  assign out_ch.cell_row          = o_row_r;
  assign out_ch.cell_col          = o_col_r;
  assign out_ch.pixel_label       = o_pix_r.label;
  assign out_ch.pixel_confidence  = o_pix_r.conf;
  assign out_ch.pixel_traversable = o_pix_r.trav;
  assign out_ch.color_blue        = o_color_r.b;
  assign out_ch.color_green       = o_color_r.g;
  assign out_ch.color_red         = o_color_r.r;

  // ---------------------------------------------------------------------------
  // Assertions
  // ---------------------------------------------------------------------------
  // a request is never taken twice in a row
  `BCSR_ASSERT_NXT(a_one_at_a_time, in_acc, !in_ch.ready, "request accepted back to back")
  // divider restarted only when free
  `BCSR_ASSERT_IMP(a_div_free, div_start, !div_st.busy, "divider started while busy")
  // a quotient only arrives while the sequencer waits for it
  `BCSR_ASSERT_IMP(a_div_done_wait, div_st.done,
                   (state_r == S_COLDIV) || (state_r == S_ROWDIV), "unexpected quotient")
  // every store update outside the clearing pass goes with a result
  `BCSR_ASSERT_IMP(a_write_has_result, mem_we && !clr_r, out_load, "pixel write without result")

endmodule

`default_nettype wire

FILE: dv/bev_confidence_splat_raster_tb.sv
// Self-checking testbench for the BEV confidence splat raster.
// Uses bcsr_pkg and the bcsr_in_if / bcsr_out_if channels from the RTL.
// A directed table runs first, then random splat and read traffic over several grid setups.
`timescale 1ns / 1ps

module bev_confidence_splat_raster_tb;
  import bcsr_pkg::*;

  localparam int GRID_MAX = 512;
  // idle limit covers the clearing pass after reset (one pixel per cycle) with margin
  localparam int WATCHDOG_CYCLES = 4 * GRID_MAX * GRID_MAX + 20000;
  localparam int SINK_HOLD_CYCLES = 400;   // long receiver hold-off, fills the pipe
  localparam int DRAIN_CYCLES = 40;
  localparam int MAX_REPORTS = 10;
  localparam int NUM_SETUPS = 6;

  // one request as the sender sees it
  typedef struct packed {
    logic                     rd;
    logic signed [COORD_W-1:0] x;
    logic signed [COORD_W-1:0] y;
    logic [LABEL_W-1:0]       lbl;
    logic [CONF_IN_W-1:0]     conf;
    logic [IO_ROW_W-1:0]      row;
    logic [IO_ROW_W-1:0]      col;
  } splat_req_t;

  // one result, field for field with the result channel
  typedef struct packed {
    logic [STATUS_W-1:0] status;
    logic [IO_ROW_W-1:0] row;
    logic [IO_ROW_W-1:0] col;
    logic [LABEL_W-1:0]  label;
    logic [CONF_W-1:0]   conf;
    logic                trav;
    logic [COLOR_W-1:0]  b;
    logic [COLOR_W-1:0]  g;
    logic [COLOR_W-1:0]  r;
  } raster_res_t;

  // directed row: typed = 1 means the answer is written out here, else predicted
  typedef struct packed {
    splat_req_t  rq;
    logic        typed;
    raster_res_t want;
  } dir_row_t;

  typedef struct {
    logic signed [COORD_W-1:0] cx;
    logic signed [COORD_W-1:0] cy;
    logic [HALF_W-1:0]         half;
    logic [CELL_W-1:0]         cell_mm;
    logic [GRID_CNT_W-1:0]     grid;
    int                        items;
    int                        src_gap;
    int                        sink_stall;
  } grid_setup_t;

  localparam raster_res_t REJECTED = '{status: ST_OUTSIDE, default: '0};

  logic                  clk = 1'b0;
  logic                  rst_n;
  logic                  cfg_we;
  logic [CFG_IDX_W-1:0]  cfg_idx;
  logic [CFG_DATA_W-1:0] cfg_wdata;

  bcsr_in_if  in_ch ();
  bcsr_out_if out_ch ();

  bev_confidence_splat_raster #(.GRID_MAX(GRID_MAX)) u_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_idx   (cfg_idx),
    .cfg_wdata (cfg_wdata),
    .in_ch     (in_ch),
    .out_ch    (out_ch)
  );

  always #4 clk = ~clk;

  // mirror of the block: pixel store plus register copies
  pix_t                      pixel_mirror [GRID_MAX*GRID_MAX];
  logic signed [COORD_W-1:0] grid_cx;
  logic signed [COORD_W-1:0] grid_cy;
  logic [HALF_W-1:0]         grid_half;
  logic [CELL_W-1:0]         grid_cell;
  logic [GRID_CNT_W-1:0]     grid_cells;

  raster_res_t due_results [$];   // answers owed by the block, oldest first
  dir_row_t    directed [$];      // directed table, walked in order

  int fail_count = 0;
  int sent_total = 0;
  int seen_status [4] = '{0, 0, 0, 0};
  int quiet_cycles = 0;
  int src_gap_pct = 0;
  int sink_stall_pct = 0;
  int hold_asks = 0;
  int holds_done = 0;

  // grid in use is grid_cells clamped to [GRID_MIN, GRID_MAX]
  function automatic int cells_in_use();
    int n;
    n = int'(grid_cells);
    if (n > GRID_MAX) n = GRID_MAX;
    if (n < GRID_MIN) n = GRID_MIN;
    return n;
  endfunction

  // pixel plus its BGR label color; anything not a known class shows gray
  function automatic raster_res_t show_pixel(logic [STATUS_W-1:0] st, int row, int col,
                                             pix_t p);
    raster_res_t res;
    res.status = st;
    res.row    = IO_ROW_W'(row);
    res.col    = IO_ROW_W'(col);
    res.label  = p.label;
    res.conf   = p.conf;
    res.trav   = p.trav;
    case (p.label)
      LBL_ROAD:       {res.b, res.g, res.r} = {8'd70,  8'd70,  8'd70};
      LBL_SIDEWALK:   {res.b, res.g, res.r} = {8'd80,  8'd120, 8'd160};
      LBL_BUILDING:   {res.b, res.g, res.r} = {8'd40,  8'd40,  8'd220};
      LBL_VEGETATION: {res.b, res.g, res.r} = {8'd40,  8'd170, 8'd20};
      LBL_DYNAMIC:    {res.b, res.g, res.r} = {8'd0,   8'd180, 8'd255};
      LBL_OTHER:      {res.b, res.g, res.r} = {8'd220, 8'd120, 8'd120};
      default:        {res.b, res.g, res.r} = {8'd180, 8'd180, 8'd180};
    endcase
    return res;
  endfunction

  // Predicts the answer to one request and updates the pixel mirror.
  function automatic raster_res_t raster_predict(splat_req_t q);
    raster_res_t   res;
    pix_t          old;
    pix_t          nxt;
    int            n;
    int            idx;
    longint        half_l, dx, dy, cl, row, col, cin, c8;
    logic [LABEL_W-1:0] lbl;
    n = cells_in_use();
    if (q.rd) begin
      // read-and-clear; outside the grid in use it answers empty and touches nothing
      old = '0;
      if (q.row < n && q.col < n) begin
        idx = int'(q.row) * GRID_MAX + int'(q.col);
        old = pixel_mirror[idx];
        pixel_mirror[idx] = '0;
      end
      return show_pixel(ST_READ, int'(q.row), int'(q.col), old);
    end
    half_l = longint'(grid_half);
    dx = longint'($signed(q.x)) - longint'(grid_cx);
    dy = longint'($signed(q.y)) - longint'(grid_cy);
    // half-open window: -half <= d < half on both axes
    if (dx < -half_l || dx >= half_l || dy < -half_l || dy >= half_l) return REJECTED;
    cl  = (grid_cell == '0) ? 64'sd1 : longint'(grid_cell);
    col = (dx + half_l) / cl;
    row = (half_l - dy) / cl;
    if (col >= n || row >= n) return REJECTED;
    cin = longint'(q.conf);
    if (cin > 65536) cin = 65536;
    c8  = (cin * 255) >> 16;
    lbl = (q.lbl == LBL_INVALID) ? LBL_NONE : q.lbl;
    idx = int'(row) * GRID_MAX + int'(col);
    old = pixel_mirror[idx];
    // ties overwrite; only a strictly stronger stored pixel wins
    if (c8 < longint'(old.conf)) return show_pixel(ST_WEAKER, int'(row), int'(col), old);
    nxt.label = lbl;
    nxt.conf  = CONF_W'(c8);
    nxt.trav  = old.trav | (lbl == LBL_ROAD) | (lbl == LBL_SIDEWALK);   // sticky
    pixel_mirror[idx] = nxt;
    return show_pixel(ST_WRITTEN, int'(row), int'(col), nxt);
  endfunction

  function automatic splat_req_t splat_of(longint x, longint y, logic [LABEL_W-1:0] lbl,
                                          int conf);
    splat_req_t q;
    q      = '0;
    q.x    = COORD_W'(x);
    q.y    = COORD_W'(y);
    q.lbl  = lbl;
    q.conf = CONF_IN_W'(conf);
    return q;
  endfunction

  function automatic splat_req_t read_of(int row, int col);
    splat_req_t q;
    q     = '0;
    q.rd  = 1'b1;
    q.row = IO_ROW_W'(row);
    q.col = IO_ROW_W'(col);
    return q;
  endfunction

  // appends one row to the directed table
  function automatic void add_row(splat_req_t rq, logic typed, raster_res_t want);
    dir_row_t d;
    d = '{rq, typed, want};
    directed.insert(directed.size(), d);
  endfunction

  // Row/column picks lean on the grid corners so pixels get hit again and again.
  function automatic int hot_index(int n);
    case ($urandom_range(0, 3))
      0:       return int'($urandom_range(0, 3));
      1:       return n - 1 - int'($urandom_range(0, 3));
      2:       return int'($urandom_range(0, n - 1));
      default: return int'($urandom_range(0, n + 3));
    endcase
  endfunction

  // Random request: mostly splats aimed at hot cells, reads of hot pixels, some noise.
  function automatic splat_req_t pick_req();
    splat_req_t q;
    int         n, roll, r_i, c_i;
    longint     cl, offx, offy, px, py;
    n      = cells_in_use();
    q.rd   = 1'b0;
    q.x    = $urandom;
    q.y    = $urandom;
    q.lbl  = LABEL_W'($urandom_range(0, 7));
    q.row  = IO_ROW_W'($urandom);
    q.col  = IO_ROW_W'($urandom);
    case ($urandom_range(0, 4))
      0:       q.conf = CONF_IN_W'($urandom_range(0, 131071));
      1:       q.conf = CONF_IN_W'($urandom_range(0, 65536));
      2:       q.conf = CONF_ONE;
      3:       q.conf = CONF_IN_W'($urandom_range(0, 600));
      default: q.conf = CONF_IN_W'($urandom_range(65000, 66000));
    endcase
    roll = int'($urandom_range(0, 99));
    if (roll < 30) begin
      q.rd = 1'b1;
      if (roll < 23) begin
        q.row = IO_ROW_W'(hot_index(n));
        q.col = IO_ROW_W'(hot_index(n));
      end
    end else if (roll < 90) begin
      r_i  = hot_index(n);
      c_i  = hot_index(n);
      cl   = (grid_cell == '0) ? 64'sd1 : longint'(grid_cell);
      // zero offset half the time puts the point right on a cell edge
      offx = $urandom_range(0, 1) ? 64'sd0 : longint'($urandom_range(0, 32'(cl - 1)));
      offy = $urandom_range(0, 1) ? 64'sd0 : longint'($urandom_range(0, 32'(cl - 1)));
      px   = longint'(grid_cx) - longint'(grid_half) + longint'(c_i) * cl + offx;
      py   = longint'(grid_cy) + longint'(grid_half) - longint'(r_i) * cl - offy;
      q.x  = COORD_W'(px);
      q.y  = COORD_W'(py);
    end
    return q;
  endfunction

  function automatic string res_text(raster_res_t v);
    return $sformatf("status=%0d row=%0d col=%0d label=%0d conf=%0d trav=%0d bgr=%0d/%0d/%0d",
                     v.status, v.row, v.col, v.label, v.conf, v.trav, v.b, v.g, v.r);
  endfunction

  task automatic note_failure(string what);
    fail_count++;
    if (fail_count <= MAX_REPORTS) $display("[%0t] MISMATCH: %s", $realtime, what);
  endtask

  // Offers one request, holds it until accepted, then books the owed answer.
  task automatic push_req(splat_req_t q, logic typed, raster_res_t want);
    raster_res_t guess;
    in_ch.valid            <= 1'b1;
    in_ch.req_type         <= q.rd;
    in_ch.point_x_mm       <= q.x;
    in_ch.point_y_mm       <= q.y;
    in_ch.point_label      <= q.lbl;
    in_ch.point_confidence <= q.conf;
    in_ch.read_row         <= q.row;
    in_ch.read_col         <= q.col;
    do @(posedge clk); while (in_ch.ready !== 1'b1);
    guess = raster_predict(q);
    due_results.insert(due_results.size(), typed ? want : guess);
    sent_total++;
  endtask

  // random sender gap; valid stays up when there is none
  task automatic idle_source();
    if (int'($urandom_range(0, 99)) < src_gap_pct) begin
      in_ch.valid <= 1'b0;
      repeat ($urandom_range(1, 19)) @(posedge clk);
    end
  endtask

  task automatic drain_results();
    in_ch.valid <= 1'b0;
    do @(posedge clk); while (due_results.size() != 0);
  endtask

  // writes all five registers; upper junk bits above each register's width must be ignored
  task automatic load_setup(grid_setup_t s);
    cfg_we    <= 1'b1;
    cfg_idx   <= CFG_CENTER_X;
    cfg_wdata <= s.cx;
    @(posedge clk);
    cfg_idx   <= CFG_CENTER_Y;
    cfg_wdata <= s.cy;
    @(posedge clk);
    cfg_idx   <= CFG_HALF;
    cfg_wdata <= {2'($urandom), s.half};
    @(posedge clk);
    cfg_idx   <= CFG_CELL;
    cfg_wdata <= {12'($urandom), s.cell_mm};
    @(posedge clk);
    cfg_idx   <= CFG_GRID;
    cfg_wdata <= {22'($urandom), s.grid};
    @(posedge clk);
    cfg_we    <= 1'b0;
    grid_cx    = s.cx;
    grid_cy    = s.cy;
    grid_half  = s.half;
    grid_cell  = s.cell_mm;
    grid_cells = s.grid;
  endtask

  // ---------------------------------------------------------------------------
  // Result side: ready with random stall bursts, plus one long hold on request.
  // ---------------------------------------------------------------------------
  initial begin : result_ready
    out_ch.ready <= 1'b1;
    forever begin
      @(posedge clk);
      if (hold_asks != holds_done) begin
        holds_done++;
        out_ch.ready <= 1'b0;
        repeat (SINK_HOLD_CYCLES) @(posedge clk);
        out_ch.ready <= 1'b1;
      end else if (int'($urandom_range(0, 99)) < sink_stall_pct) begin
        out_ch.ready <= 1'b0;
        repeat ($urandom_range(1, 19)) @(posedge clk);
        out_ch.ready <= 1'b1;
      end
    end
  end

  // Compare every accepted result against the oldest owed answer.
  always @(posedge clk) begin : result_check
    raster_res_t got;
    raster_res_t exp_res;
    string       bad;
    if (rst_n === 1'b1 && out_ch.valid === 1'b1 && out_ch.ready === 1'b1) begin
      got.status = out_ch.status;
      got.row    = out_ch.cell_row;
      got.col    = out_ch.cell_col;
      got.label  = out_ch.pixel_label;
      got.conf   = out_ch.pixel_confidence;
      got.trav   = out_ch.pixel_traversable;
      got.b      = out_ch.color_blue;
      got.g      = out_ch.color_green;
      got.r      = out_ch.color_red;
      if (due_results.size() == 0) begin
        note_failure({"result with nothing owed: ", res_text(got)});
      end else begin
        exp_res = due_results.pop_front();
        seen_status[exp_res.status]++;
        bad = "";
        if (got.status !== exp_res.status) bad = {bad, " status"};
        if (got.row    !== exp_res.row)    bad = {bad, " row"};
        if (got.col    !== exp_res.col)    bad = {bad, " col"};
        if (got.label  !== exp_res.label)  bad = {bad, " label"};
        if (got.conf   !== exp_res.conf)   bad = {bad, " conf"};
        if (got.trav   !== exp_res.trav)   bad = {bad, " trav"};
        if (got.b      !== exp_res.b)      bad = {bad, " blue"};
        if (got.g      !== exp_res.g)      bad = {bad, " green"};
        if (got.r      !== exp_res.r)      bad = {bad, " red"};
        if (bad != "")
          note_failure({"field(s)", bad, "\n  expected ", res_text(exp_res),
                        "\n  actual   ", res_text(got)});
      end
    end
  end

  // Watchdog: ends the run after too long without any handshake on either channel.
  always @(posedge clk) begin
    if ((in_ch.valid === 1'b1 && in_ch.ready === 1'b1) ||
        (out_ch.valid === 1'b1 && out_ch.ready === 1'b1)) quiet_cycles = 0;
    else quiet_cycles++;
    if (quiet_cycles >= WATCHDOG_CYCLES) begin
      $display("Timeout: no request or result moved for %0d cycles", quiet_cycles);
      $display("== FAIL ==");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // Stimulus
  // ---------------------------------------------------------------------------
  initial begin : stimulus
    grid_setup_t setups [NUM_SETUPS];
    int          p, k;

    rst_n                  <= 1'b0;
    cfg_we                 <= 1'b0;
    cfg_idx                <= CFG_CENTER_X;
    cfg_wdata              <= '0;
    in_ch.valid            <= 1'b0;
    in_ch.req_type         <= 1'b0;
    in_ch.point_x_mm       <= '0;
    in_ch.point_y_mm       <= '0;
    in_ch.point_label      <= LBL_NONE;
    in_ch.point_confidence <= '0;
    in_ch.read_row         <= '0;
    in_ch.read_col         <= '0;
    foreach (pixel_mirror[j]) pixel_mirror[j] = '0;
    grid_cx    = '0;
    grid_cy    = '0;
    grid_half  = RST_HALF;
    grid_cell  = RST_CELL;
    grid_cells = RST_GRID;

    repeat (4) @(posedge clk);
    rst_n <= 1'b1;

    // Directed table, reset register values: center 0,0, half 50000, cell 200, grid 500.
    // Requests wait for ready until the clearing pass is done.
    add_row(read_of(0, 0), 1'b1, show_pixel(ST_READ, 0, 0, '0));
    // read past the grid in use: empty and gray
    add_row(read_of(511, 511), 1'b1, show_pixel(ST_READ, 511, 511, '0));
    // window edges: -half is in, +half is out
    add_row(splat_of(-50001, 0, LBL_ROAD, 100), 1'b1, REJECTED);
    add_row(splat_of(50000, 0, LBL_ROAD, 100), 1'b1, REJECTED);
    add_row(splat_of(0, 50000, LBL_ROAD, 100), 1'b1, REJECTED);
    add_row(splat_of(-64'sd2147483648, 2147483647, LBL_OTHER, 65536), 1'b1, REJECTED);
    // full confidence road at the top-left pixel
    add_row(splat_of(-50000, 49999, LBL_ROAD, 65536), 1'b1,
            show_pixel(ST_WRITTEN, 0, 0, pix_t'{1'b1, 8'd255, LBL_ROAD}));
    // clamped confidence ties 255 and overwrites; traversable stays set
    add_row(splat_of(-50000, 49999, LBL_BUILDING, 131071), 1'b1,
            show_pixel(ST_WRITTEN, 0, 0, pix_t'{1'b1, 8'd255, LBL_BUILDING}));
    // weaker point leaves the pixel alone and reports what is stored
    add_row(splat_of(-50000, 49999, LBL_VEGETATION, 0), 1'b1,
            show_pixel(ST_WEAKER, 0, 0, pix_t'{1'b1, 8'd255, LBL_BUILDING}));
    add_row(read_of(0, 0), 1'b1,
            show_pixel(ST_READ, 0, 0, pix_t'{1'b1, 8'd255, LBL_BUILDING}));
    // the read cleared it
    add_row(read_of(0, 0), 1'b1, show_pixel(ST_READ, 0, 0, '0));
    // inside the window but one row past the grid
    add_row(splat_of(49999, -50000, LBL_INVALID, 1), 1'b1, REJECTED);
    // label 7 stores as none; 257 scales down to 0
    add_row(splat_of(49999, -49800, LBL_INVALID, 257), 1'b1,
            show_pixel(ST_WRITTEN, 499, 499, '0));
    add_row(splat_of(0, 0, LBL_SIDEWALK, 32768), 1'b1,
            show_pixel(ST_WRITTEN, 250, 250, pix_t'{1'b1, 8'd127, LBL_SIDEWALK}));
    add_row(splat_of(0, 0, LBL_DYNAMIC, 32768), 1'b1,
            show_pixel(ST_WRITTEN, 250, 250, pix_t'{1'b1, 8'd127, LBL_DYNAMIC}));
    add_row(splat_of(199, 1, LBL_OTHER, 65535), 1'b0, '0);
    add_row(read_of(249, 250), 1'b0, '0);
    add_row(read_of(250, 250), 1'b1,
            show_pixel(ST_READ, 250, 250, pix_t'{1'b1, 8'd127, LBL_DYNAMIC}));
    add_row(splat_of(100, 100, LBL_ROAD, 1000), 1'b0, '0);
    add_row(splat_of(-100, -100, LBL_NONE, 70000), 1'b0, '0);
    add_row(read_of(499, 499), 1'b0, '0);

    src_gap_pct    = 25;
    sink_stall_pct = 20;
    foreach (directed[j]) begin
      push_req(directed[j].rq, directed[j].typed, directed[j].want);
      idle_source();
    end

    // Grid setups for the random part. Includes the smallest grid, a grid count that
    // clamps high and one that clamps low, zero cell size, the largest half and cell,
    // and extreme centers. Setup 4 shrinks the grid over written pixels; setup 5 widens
    // it again so they can be read back.
    setups[0] = '{cx: 32'sd1000, cy: -32'sd2000, half: 30'd3200, cell_mm: 20'd100,
                  grid: 10'd32, items: 220, src_gap: 20, sink_stall: 15};
    setups[1] = '{cx: 32'sd0, cy: 32'sd0, half: 30'h3fff_ffff, cell_mm: 20'hf_ffff,
                  grid: 10'h3ff, items: 120, src_gap: 10, sink_stall: 10};
    setups[2] = '{cx: 32'sh8000_0000, cy: 32'sh7fff_ffff, half: 30'd20, cell_mm: 20'd0,
                  grid: 10'd0, items: 150, src_gap: 0, sink_stall: 0};
    setups[3] = '{cx: 32'sh7fff_ffff, cy: 32'sh8000_0000, half: 30'd1, cell_mm: 20'd20,
                  grid: 10'd513, items: 80, src_gap: 30, sink_stall: 30};
    setups[4] = '{cx: -32'sd777, cy: 32'sd123456, half: 30'd50000, cell_mm: 20'd200,
                  grid: 10'd40, items: 180, src_gap: 15, sink_stall: 10};
    setups[5] = '{cx: 32'sd0, cy: 32'sd0, half: 30'd50000, cell_mm: 20'd200,
                  grid: 10'd500, items: 250, src_gap: 10, sink_stall: 10};

    for (p = 0; p < NUM_SETUPS; p++) begin
      // registers change only with nothing in flight
      drain_results();
      load_setup(setups[p]);
      src_gap_pct    = setups[p].src_gap;
      sink_stall_pct = setups[p].sink_stall;
      for (k = 0; k < setups[p].items; k++) begin
        // receiver holds off for a long stretch while requests keep coming
        if (p == 0 && k == 60) hold_asks++;
        // sender stops until every owed result is back
        if (p == 4 && k == 90) drain_results();
        // back-to-back tail, no idling on either side
        if (p == NUM_SETUPS - 1 && k == setups[p].items - 100) begin
          src_gap_pct    = 0;
          sink_stall_pct = 0;
        end
        push_req(pick_req(), 1'b0, '0);
        idle_source();
      end
    end

    drain_results();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (due_results.size() != 0)
      note_failure($sformatf("%0d result(s) never arrived", due_results.size()));

    $display("Sent %0d splat/read requests over %0d grid setups (clamped grids, zero cell,",
             sent_total, NUM_SETUPS + 1);
    $display("  extreme centers); results: %0d written, %0d rejected, %0d weaker, %0d reads",
             seen_status[ST_WRITTEN], seen_status[ST_OUTSIDE], seen_status[ST_WEAKER],
             seen_status[ST_READ]);
    if (fail_count == 0) begin
      $display("== PASS ==");
    end else begin
      $display("%0d failure(s)", fail_count);
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule

FILE: sim.f
+incdir+hw/rtl
hw/rtl/bcsr_pkg.sv
hw/rtl/bcsr_in_if.sv
hw/rtl/bcsr_out_if.sv
hw/rtl/bcsr_div.sv
hw/rtl/bev_confidence_splat_raster.sv
dv/bev_confidence_splat_raster_tb.sv
